// ----- rtl/pcb_pkg.sv -----
// Shared types, widths and constants for the power-cell bounds block.
// Used by the channel interfaces, the serial arithmetic units and the top level.
// Depends on nothing else.
package pcb_pkg;

   localparam int MAX_CELLS = 65536;

   localparam int POS_W = 32;
   localparam int FRAC_W = 16;
   localparam int INDEX_W = 16;
   localparam int KIND_W = 2;

   // Differences and sums of two positions or weights.
   localparam int GAP_W = POS_W + 1;
   // Unsigned quotient of (|dw| << 16) / gap, one bit per divider step.
   localparam int QUO_W = POS_W + FRAC_W;
   localparam int Q_W = QUO_W + 1;
   localparam int T_W = Q_W + 1;
   localparam int BALL_W = POS_W + 1;

   // floor(sqrt(w << 16)) for w below 2^31 needs 24 bits; two radicand bits per step.
   localparam int RADIUS_W = (POS_W - 1 + FRAC_W + 1) / 2;
   localparam int SQ_IN_W = 2 * RADIUS_W;
   localparam int SQ_REM_W = RADIUS_W + 2;

   localparam int DIV_STEPS = QUO_W;
   localparam int SQRT_STEPS = RADIUS_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
   localparam int SQRT_CNT_W = $clog2(SQRT_STEPS + 1);

   localparam logic [INDEX_W-1:0] CELL_TOP =
      INDEX_W'(((MAX_CELLS - 1) > 65535) ? 65535 : (MAX_CELLS - 1));

   localparam logic signed [POS_W-1:0] Q_MIN_CODE = {1'b1, {(POS_W-1){1'b0}}};
   localparam logic signed [POS_W-1:0] Q_MAX_CODE = {1'b0, {(POS_W-1){1'b1}}};

   typedef enum logic [KIND_W-1:0] {
      KIND_INF  = 2'd0,
      KIND_CELL = 2'd1,
      KIND_BALL = 2'd2
   } kind_type;

   typedef struct packed {
      logic [INDEX_W-1:0]      cell_index;
      logic signed [POS_W-1:0] left_bound;
      logic signed [POS_W-1:0] right_bound;
      kind_type                left_kind;
      kind_type                right_kind;
      logic                    last_cell;
      logic                    order_fault;
   } result_type;

   typedef struct packed {
      logic signed [POS_W-1:0] value;
      kind_type                kind;
   } bound_type;

endpackage

// ----- rtl/pcb_ifs.sv -----
// Valid/ready channel interfaces for seed items in and cell items out.
// Field widths come from pcb_pkg.
interface pcb_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [pcb_pkg::POS_W-1:0] seed_pos;
   logic signed [pcb_pkg::POS_W-1:0] seed_weight;
   logic                             last_seed;

   modport source (output valid, output seed_pos, output seed_weight,
                   output last_seed, input ready);
   modport sink (input valid, input seed_pos, input seed_weight,
                 input last_seed, output ready);
endinterface

interface pcb_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [pcb_pkg::INDEX_W-1:0]        cell_index;
   logic signed [pcb_pkg::POS_W-1:0]   left_bound;
   logic signed [pcb_pkg::POS_W-1:0]   right_bound;
   logic [pcb_pkg::KIND_W-1:0]         left_kind;
   logic [pcb_pkg::KIND_W-1:0]         right_kind;
   logic                               last_cell;
   logic                               order_fault;

   modport source (output valid, output cell_index, output left_bound,
                   output right_bound, output left_kind, output right_kind,
                   output last_cell, output order_fault, input ready);
   modport sink (input valid, input cell_index, input left_bound,
                 input right_bound, input left_kind, input right_kind,
                 input last_cell, input order_fault, output ready);
endinterface

// ----- rtl/pcb_divider.sv -----
// Bit-serial restoring divider: (dividend << FRAC_W) / divisor, one quotient bit per cycle.
// Widths and step count come from pcb_pkg.
module pcb_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pcb_pkg::POS_W-1:0]   dividend,
   input  logic [pcb_pkg::POS_W-1:0]   divisor,
   output logic                        busy,
   output logic [pcb_pkg::QUO_W-1:0]   quotient
);

   logic [pcb_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [pcb_pkg::QUO_W-1:0]     num_ff, num_in;
   logic [pcb_pkg::POS_W-1:0]     rem_ff, rem_in;
   logic [pcb_pkg::POS_W-1:0]     den_ff, den_in;
   logic [pcb_pkg::POS_W:0]       shifted;
   logic [pcb_pkg::POS_W:0]       diff;

   // The numerator shifts out at the top while quotient bits shift in at the bottom.
   always_comb begin
      shifted = {rem_ff, num_ff[pcb_pkg::QUO_W-1]};
      diff = shifted - {1'b0, den_ff};
      cnt_in = cnt_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      if (start) begin
         cnt_in = pcb_pkg::DIV_CNT_W'(pcb_pkg::DIV_STEPS);
         num_in = {dividend, {pcb_pkg::FRAC_W{1'b0}}};
         rem_in = '0;
         den_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - pcb_pkg::DIV_CNT_W'(1);
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = diff[pcb_pkg::POS_W-1:0];
            num_in = {num_ff[pcb_pkg::QUO_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[pcb_pkg::POS_W-1:0];
            num_in = {num_ff[pcb_pkg::QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = (cnt_ff != '0);
   assign quotient = num_ff;

endmodule

// ----- rtl/pcb_isqrt.sv -----
// Bit-serial integer square root of max(0, weight) << FRAC_W, one root bit per cycle.
// Widths and step count come from pcb_pkg.
module pcb_isqrt (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [pcb_pkg::POS_W-1:0] weight,
   output logic                             busy,
   output logic [pcb_pkg::RADIUS_W-1:0]     root
);

   logic [pcb_pkg::SQRT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [pcb_pkg::SQ_IN_W-1:0]    rad_ff, rad_in;
   logic [pcb_pkg::SQ_REM_W-1:0]   rem_ff, rem_in;
   logic [pcb_pkg::RADIUS_W-1:0]   root_ff, root_in;
   logic [pcb_pkg::SQ_REM_W+1:0]   shifted;
   logic [pcb_pkg::SQ_REM_W+1:0]   trial;
   logic [pcb_pkg::SQ_REM_W+1:0]   diff;

   always_comb begin
      shifted = {rem_ff, rad_ff[pcb_pkg::SQ_IN_W-1 -: 2]};
      trial = {2'b00, root_ff, 2'b01};
      diff = shifted - trial;
      cnt_in = cnt_ff;
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      if (start) begin
         cnt_in = pcb_pkg::SQRT_CNT_W'(pcb_pkg::SQRT_STEPS);
         // A negative weight has no ball radius beyond zero.
         if (weight[pcb_pkg::POS_W-1]) begin
            rad_in = '0;
         end else begin
            rad_in = {1'b0, weight[pcb_pkg::POS_W-2:0], {pcb_pkg::FRAC_W{1'b0}}};
         end
         rem_in = '0;
         root_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - pcb_pkg::SQRT_CNT_W'(1);
         rad_in = {rad_ff[pcb_pkg::SQ_IN_W-3:0], 2'b00};
         if (shifted >= trial) begin
            rem_in = diff[pcb_pkg::SQ_REM_W-1:0];
            root_in = {root_ff[pcb_pkg::RADIUS_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[pcb_pkg::SQ_REM_W-1:0];
            root_in = {root_ff[pcb_pkg::RADIUS_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
   end

   assign busy = (cnt_ff != '0);
   assign root = root_ff;

endmodule

// ----- rtl/power_cell_bounds_1d.sv -----
// One-dimensional power-diagram cells from a sorted stream of weighted seeds.
// Depends on pcb_pkg, the channel interfaces, pcb_divider and pcb_isqrt.
//
// Seeds come in ascending position order; each accepted item emits the cell of the
// previously held seed (if any) and, when last_seed is set, also the cell of the new
// seed, so an item gives zero, one or two cell items. One item is worked on at a
// time. An item that closes a cell waits on the 48-step bit-serial divider that
// forms the boundary; the 24-step serial square root for the ball radius runs
// alongside it. An item that only opens a set waits on the square root alone. A
// finished cell waits in the output register, and the next item is taken while it
// waits. The ball-cut enable is written through csr_wr_en and csr_wr_data; the user
// must write it only while the block is idle, which the block does not enforce.
module power_cell_bounds_1d (
   input  logic            clock,
   input  logic            reset,
   pcb_req_if.sink         req_ch,
   pcb_rsp_if.source       rsp_ch,
   input  logic            csr_wr_en,
   input  logic            csr_wr_data
);

   typedef enum logic [9:0] {
      S_IDLE     = 10'b00_0000_0001,
      S_DIFF     = 10'b00_0000_0010,
      S_DIVSTART = 10'b00_0000_0100,
      S_DIV      = 10'b00_0000_1000,
      S_SUM      = 10'b00_0001_0000,
      S_HALF     = 10'b00_0010_0000,
      S_EMIT1    = 10'b00_0100_0000,
      S_SQWAIT   = 10'b00_1000_0000,
      S_BALL     = 10'b01_0000_0000,
      S_EMIT2    = 10'b10_0000_0000
   } state_type;

   localparam logic signed [pcb_pkg::T_W-1:0] T_MAX = pcb_pkg::T_W'(pcb_pkg::Q_MAX_CODE);
   localparam logic signed [pcb_pkg::T_W-1:0] T_MIN = pcb_pkg::T_W'(pcb_pkg::Q_MIN_CODE);

   state_type state_ff, state_in;
   logic enable_ff, enable_in;
   logic have_prev_ff, have_prev_in;
   logic [pcb_pkg::INDEX_W-1:0] counter_ff, counter_in;
   logic signed [pcb_pkg::POS_W-1:0] open_left_ff, open_left_in;
   pcb_pkg::kind_type open_kind_ff, open_kind_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic signed [pcb_pkg::POS_W-1:0] cur_pos_ff, cur_pos_in;
   logic signed [pcb_pkg::POS_W-1:0] cur_w_ff, cur_w_in;
   logic cur_last_ff, cur_last_in;
   logic signed [pcb_pkg::POS_W-1:0] prev_pos_ff, prev_pos_in;
   logic signed [pcb_pkg::POS_W-1:0] prev_w_ff, prev_w_in;
   logic signed [pcb_pkg::GAP_W-1:0] gap_ff, gap_in;
   logic signed [pcb_pkg::GAP_W-1:0] dw_ff, dw_in;
   logic signed [pcb_pkg::GAP_W-1:0] psum_ff, psum_in;
   logic signed [pcb_pkg::Q_W-1:0] q_ff, q_in;
   logic signed [pcb_pkg::T_W-1:0] t_ff, t_in;
   logic signed [pcb_pkg::POS_W-1:0] x1_ff, x1_in;
   logic fault_ff, fault_in;
   logic signed [pcb_pkg::BALL_W-1:0] seed_bl_ff, seed_bl_in;
   logic signed [pcb_pkg::BALL_W-1:0] seed_br_ff, seed_br_in;
   pcb_pkg::result_type res_ff, res_in;

   logic accept;
   logic out_free;
   logic div_start;
   logic div_busy;
   logic [pcb_pkg::QUO_W-1:0] div_quo;
   logic [pcb_pkg::GAP_W-1:0] abs_dw;
   logic sq_busy;
   logic [pcb_pkg::RADIUS_W-1:0] sq_root;
   logic signed [pcb_pkg::Q_W-1:0] q_mag;
   logic signed [pcb_pkg::T_W-1:0] half_floor;
   logic signed [pcb_pkg::T_W-1:0] half_trunc;
   logic signed [pcb_pkg::BALL_W-1:0] radius_s;
   pcb_pkg::bound_type left_b;
   pcb_pkg::bound_type right_b;

   // Under ball cut a bound outside [pos - r, pos + r] moves onto the ball edge;
   // the infinite codes are compared as plain numbers.
   function automatic pcb_pkg::bound_type clamp_bound(
      input logic signed [pcb_pkg::POS_W-1:0]  x,
      input pcb_pkg::kind_type                 k,
      input logic signed [pcb_pkg::BALL_W-1:0] bl,
      input logic signed [pcb_pkg::BALL_W-1:0] br,
      input logic                              en
   );
      pcb_pkg::bound_type b;
      logic signed [pcb_pkg::BALL_W-1:0] xe;
      xe = pcb_pkg::BALL_W'(x);
      b.value = x;
      b.kind = k;
      if (en && (xe < bl)) begin
         b.value = bl[pcb_pkg::POS_W-1:0];
         b.kind = pcb_pkg::KIND_BALL;
      end else if (en && (xe > br)) begin
         b.value = br[pcb_pkg::POS_W-1:0];
         b.kind = pcb_pkg::KIND_BALL;
      end
      return b;
   endfunction

   pcb_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (abs_dw[pcb_pkg::POS_W-1:0]),
      .divisor  (gap_ff[pcb_pkg::POS_W-1:0]),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   pcb_isqrt u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .weight (req_ch.seed_weight),
      .busy   (sq_busy),
      .root   (sq_root)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      abs_dw = dw_ff[pcb_pkg::GAP_W-1] ? -dw_ff : dw_ff;
      q_mag = $signed({1'b0, div_quo});
      half_floor = t_ff >>> 1;
      // Halving rounds toward zero, so a negative odd sum moves up by one.
      half_trunc = half_floor
         + $signed({{(pcb_pkg::T_W-1){1'b0}}, t_ff[pcb_pkg::T_W-1] & t_ff[0]});
      radius_s = pcb_pkg::BALL_W'($signed({1'b0, sq_root}));
      if (state_ff == S_EMIT2) begin
         right_b = clamp_bound(pcb_pkg::Q_MAX_CODE, pcb_pkg::KIND_INF,
                               seed_bl_ff, seed_br_ff, enable_ff);
      end else begin
         right_b = clamp_bound(x1_ff, pcb_pkg::KIND_CELL,
                               seed_bl_ff, seed_br_ff, enable_ff);
      end
      left_b = clamp_bound(open_left_ff, open_kind_ff, seed_bl_ff, seed_br_ff, enable_ff);
   end

   always_comb begin
      state_in = state_ff;
      enable_in = csr_wr_en ? csr_wr_data : enable_ff;
      have_prev_in = have_prev_ff;
      counter_in = counter_ff;
      open_left_in = open_left_ff;
      open_kind_in = open_kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      cur_pos_in = cur_pos_ff;
      cur_w_in = cur_w_ff;
      cur_last_in = cur_last_ff;
      prev_pos_in = prev_pos_ff;
      prev_w_in = prev_w_ff;
      gap_in = gap_ff;
      dw_in = dw_ff;
      psum_in = psum_ff;
      q_in = q_ff;
      t_in = t_ff;
      x1_in = x1_ff;
      fault_in = fault_ff;
      seed_bl_in = seed_bl_ff;
      seed_br_in = seed_br_ff;
      res_in = res_ff;
      div_start = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cur_pos_in = req_ch.seed_pos;
               cur_w_in = req_ch.seed_weight;
               cur_last_in = req_ch.last_seed;
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            gap_in = pcb_pkg::GAP_W'(cur_pos_ff) - pcb_pkg::GAP_W'(prev_pos_ff);
            dw_in = pcb_pkg::GAP_W'(cur_w_ff) - pcb_pkg::GAP_W'(prev_w_ff);
            psum_in = pcb_pkg::GAP_W'(cur_pos_ff) + pcb_pkg::GAP_W'(prev_pos_ff);
            state_in = have_prev_ff ? S_DIVSTART : S_SQWAIT;
         end
         S_DIVSTART: begin
            if (!gap_ff[pcb_pkg::GAP_W-1] && (gap_ff != '0)) begin
               div_start = 1'b1;
               fault_in = 1'b0;
               state_in = S_DIV;
            end else begin
               // Seeds out of order or coincident: the quotient counts as zero.
               q_in = '0;
               fault_in = 1'b1;
               state_in = S_SUM;
            end
         end
         S_DIV: begin
            if (!div_busy) begin
               q_in = dw_ff[pcb_pkg::GAP_W-1] ? -q_mag : q_mag;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            t_in = pcb_pkg::T_W'(psum_ff) - pcb_pkg::T_W'(q_ff);
            state_in = S_HALF;
         end
         S_HALF: begin
            if (half_trunc > T_MAX) begin
               x1_in = pcb_pkg::Q_MAX_CODE;
            end else if (half_trunc < T_MIN) begin
               x1_in = pcb_pkg::Q_MIN_CODE;
            end else begin
               x1_in = half_trunc[pcb_pkg::POS_W-1:0];
            end
            state_in = S_EMIT1;
         end
         S_EMIT1: begin
            if (out_free) begin
               res_in.cell_index = counter_ff;
               res_in.left_bound = left_b.value;
               res_in.left_kind = left_b.kind;
               res_in.right_bound = right_b.value;
               res_in.right_kind = right_b.kind;
               res_in.last_cell = 1'b0;
               res_in.order_fault = fault_ff;
               rsp_valid_in = 1'b1;
               open_left_in = x1_ff;
               open_kind_in = pcb_pkg::KIND_CELL;
               if (counter_ff < pcb_pkg::CELL_TOP) begin
                  counter_in = counter_ff + pcb_pkg::INDEX_W'(1);
               end
               state_in = S_SQWAIT;
            end
         end
         S_SQWAIT: begin
            if (!sq_busy) begin
               state_in = S_BALL;
            end
         end
         S_BALL: begin
            // The held seed's ball is no longer needed, so the new seed's ball
            // takes its place here.
            seed_bl_in = pcb_pkg::BALL_W'(cur_pos_ff) - radius_s;
            seed_br_in = pcb_pkg::BALL_W'(cur_pos_ff) + radius_s;
            if (cur_last_ff) begin
               state_in = S_EMIT2;
            end else begin
               prev_pos_in = cur_pos_ff;
               prev_w_in = cur_w_ff;
               have_prev_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_EMIT2: begin
            if (out_free) begin
               res_in.cell_index = counter_ff;
               res_in.left_bound = left_b.value;
               res_in.left_kind = left_b.kind;
               res_in.right_bound = right_b.value;
               res_in.right_kind = right_b.kind;
               res_in.last_cell = 1'b1;
               res_in.order_fault = 1'b0;
               rsp_valid_in = 1'b1;
               open_left_in = pcb_pkg::Q_MIN_CODE;
               open_kind_in = pcb_pkg::KIND_INF;
               have_prev_in = 1'b0;
               counter_in = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         enable_ff <= 1'b0;
         have_prev_ff <= 1'b0;
         counter_ff <= '0;
         open_left_ff <= pcb_pkg::Q_MIN_CODE;
         open_kind_ff <= pcb_pkg::KIND_INF;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         enable_ff <= enable_in;
         have_prev_ff <= have_prev_in;
         counter_ff <= counter_in;
         open_left_ff <= open_left_in;
         open_kind_ff <= open_kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_pos_ff <= cur_pos_in;
      cur_w_ff <= cur_w_in;
      cur_last_ff <= cur_last_in;
      prev_pos_ff <= prev_pos_in;
      prev_w_ff <= prev_w_in;
      gap_ff <= gap_in;
      dw_ff <= dw_in;
      psum_ff <= psum_in;
      q_ff <= q_in;
      t_ff <= t_in;
      x1_ff <= x1_in;
      fault_ff <= fault_in;
      seed_bl_ff <= seed_bl_in;
      seed_br_ff <= seed_br_in;
      res_ff <= res_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.cell_index = res_ff.cell_index;
   assign rsp_ch.left_bound = res_ff.left_bound;
   assign rsp_ch.right_bound = res_ff.right_bound;
   assign rsp_ch.left_kind = res_ff.left_kind;
   assign rsp_ch.right_kind = res_ff.right_kind;
   assign rsp_ch.last_cell = res_ff.last_cell;
   assign rsp_ch.order_fault = res_ff.order_fault;

endmodule
